### src/cbu_pkg.sv
// Shared types and constants for the 2x bilinear RGB upscaler.
// Used by the top level, by its port checker and by the testbench; depends on nothing else.
package cbu_pkg;

   // Pixel and channel widths.
   localparam int CHAN_W = 8;
   localparam int PIX_W  = 3 * CHAN_W;

   // Configuration port.
   localparam int CSR_ADDR_W = 1;
   localparam int CSR_DATA_W = 13;

   // Register indexes.
   localparam logic [CSR_ADDR_W-1:0] REG_SRC_WIDTH  = 1'd0;
   localparam logic [CSR_ADDR_W-1:0] REG_SRC_HEIGHT = 1'd1;

   // Geometry widths.
   localparam int WIDTH_W  = 12;
   localparam int HEIGHT_W = 13;
   localparam int ROW_W    = 12;
   localparam int DCOL_W   = 12;
   localparam int DROW_W   = 13;

   // Largest frame height in source rows.
   localparam logic [HEIGHT_W-1:0] MAX_HEIGHT = 13'd4096;

   typedef logic [PIX_W-1:0] pixel_type;

endpackage

### src/cbu_ram.sv
// Generic single-clock RAM with one write port and one registered read port.
// Read-first: a read and a write of the same entry in one cycle return the old data.
module cbu_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 2048
) (
   input  logic                                  clock,
   input  logic                                  we,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  logic [WIDTH-1:0]                      wdata,
   input  logic                                  re,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic [WIDTH-1:0]                      rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // Registered read, held while no read is issued.
   always_ff @(posedge clock) begin
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
   end

   assign rdata = rdata_ff;

endmodule

### src/color_bilinear_upscale_2x.sv
// 2x bilinear enlargement of an RGB image streamed in raster order. Each source
// pixel becomes a 2x2 block of destination pixels, sent one pixel per cycle while
// rsp_stall is low, with its destination column and row; a block goes out once
// its right, lower and lower-right neighbors have arrived, so pixels of the first
// row release nothing (unless the frame has one row) and the last pixel of a
// frame releases up to 16 outputs. The output port moves one pixel per cycle when
// not stalled, and that port sets the rate: stage one holds the next item while
// the emitter sends the pixels of the last, and an item that releases none
// retires from stage one without the emitter. The previous row lives in a
// MAX_WIDTH-entry line RAM read and written at the item's column in the cycle it
// is taken; it needs no clearing after reset. Writing either register restarts
// the frame at its first pixel; the user must write only while no items are in
// flight, and the block itself does not enforce this.
module color_bilinear_upscale_2x #(
   parameter int MAX_WIDTH = 2048
) (
   input  logic                               clock,
   input  logic                               reset,
   // Source pixels.
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic [cbu_pkg::CHAN_W-1:0]         req_red_in,
   input  logic [cbu_pkg::CHAN_W-1:0]         req_green_in,
   input  logic [cbu_pkg::CHAN_W-1:0]         req_blue_in,
   // Destination pixels.
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic [cbu_pkg::CHAN_W-1:0]         rsp_red_out,
   output logic [cbu_pkg::CHAN_W-1:0]         rsp_green_out,
   output logic [cbu_pkg::CHAN_W-1:0]         rsp_blue_out,
   output logic [cbu_pkg::DCOL_W-1:0]         rsp_dest_col,
   output logic [cbu_pkg::DROW_W-1:0]         rsp_dest_row,
   output logic                               rsp_run_last,
   // Configuration writes.
   input  logic                               csr_we,
   input  logic [cbu_pkg::CSR_ADDR_W-1:0]     csr_addr,
   input  logic [cbu_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   localparam int COL_W = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
   localparam int CNT_W = 14;
   localparam logic [cbu_pkg::WIDTH_W-1:0] WIDTH_RESET =
      cbu_pkg::WIDTH_W'((MAX_WIDTH < 2048) ? MAX_WIDTH : 2048);
   localparam logic [cbu_pkg::WIDTH_W-1:0] WIDTH_CLAMP =
      cbu_pkg::WIDTH_W'((MAX_WIDTH < 4095) ? MAX_WIDTH : 4095);
   localparam logic [COL_W-1:0]          COL_ONE = COL_W'(1);
   localparam logic [cbu_pkg::ROW_W-1:0] ROW_ONE = cbu_pkg::ROW_W'(1);

   // Block codes, in emission order.
   localparam logic [1:0] BLK_UP_LEFT  = 2'd0; // block of the pixel above-left
   localparam logic [1:0] BLK_UP       = 2'd1; // block of the pixel above (right column)
   localparam logic [1:0] BLK_LEFT     = 2'd2; // block of the pixel to the left (last row)
   localparam logic [1:0] BLK_SELF     = 2'd3; // block of this pixel (last pixel of frame)

   localparam logic [1:0] QUAD_LAST = 2'd3;

   // Per-channel mean of four pixels, truncated.
   function automatic cbu_pkg::pixel_type avg4(input cbu_pkg::pixel_type a,
                                               input cbu_pkg::pixel_type b,
                                               input cbu_pkg::pixel_type c,
                                               input cbu_pkg::pixel_type d);
      logic [cbu_pkg::CHAN_W+1:0] sum;
      cbu_pkg::pixel_type         res;
      res = '0;
      for (int ch = 0; ch < 3; ch++) begin
         sum = 10'(a[ch*cbu_pkg::CHAN_W +: cbu_pkg::CHAN_W])
             + 10'(b[ch*cbu_pkg::CHAN_W +: cbu_pkg::CHAN_W])
             + 10'(c[ch*cbu_pkg::CHAN_W +: cbu_pkg::CHAN_W])
             + 10'(d[ch*cbu_pkg::CHAN_W +: cbu_pkg::CHAN_W]);
         res[ch*cbu_pkg::CHAN_W +: cbu_pkg::CHAN_W] = sum[cbu_pkg::CHAN_W+1:2];
      end
      return res;
   endfunction

   // ------------------------------------------------------------------
   // Declarations
   // ------------------------------------------------------------------
   logic [cbu_pkg::WIDTH_W-1:0]  width_ff, width_in;
   logic [cbu_pkg::HEIGHT_W-1:0] height_ff, height_in;
   logic [COL_W-1:0]             col_ff, col_in;
   logic [cbu_pkg::ROW_W-1:0]    row_ff, row_in;
   cbu_pkg::pixel_type           left_cur_ff, left_cur_in;
   cbu_pkg::pixel_type           left_above_ff, left_above_in;

   logic                         s1_valid_ff, s1_valid_in;
   cbu_pkg::pixel_type           s1_cur_ff, s1_lc_ff;
   logic [COL_W-1:0]             s1_col_ff;
   logic [cbu_pkg::ROW_W-1:0]    s1_row_ff;
   logic [3:0]                   s1_mask_ff;

   logic                         job_valid_ff, job_valid_in;
   logic [3:0]                   job_mask_ff, job_mask_in;
   logic [1:0]                   quad_ff, quad_in;
   cbu_pkg::pixel_type           job_la_ff, job_above_ff, job_lc_ff, job_cur_ff;
   logic [COL_W-1:0]             job_col_ff;
   logic [cbu_pkg::ROW_W-1:0]    job_row_ff;

   logic                         rsp_valid_ff, rsp_valid_in;
   cbu_pkg::pixel_type           rsp_pix_ff;
   logic [cbu_pkg::DCOL_W-1:0]   rsp_col_ff;
   logic [cbu_pkg::DROW_W-1:0]   rsp_row_ff;
   logic                         rsp_last_ff;

   cbu_pkg::pixel_type           req_pix;
   cbu_pkg::pixel_type           ram_rdata;
   logic                         accept;
   logic                         last_col, last_row;
   logic [3:0]                   new_mask;
   logic                         out_load, emit, job_done, job_free;
   logic                         s1_leave, s1_to_job;
   logic [1:0]                   blk;
   logic [3:0]                   mask_rest;
   cbu_pkg::pixel_type           op_a, op_b, op_c, op_d, emit_pix;
   logic [COL_W-1:0]             blk_col;
   logic [cbu_pkg::ROW_W-1:0]    blk_row;
   logic [cbu_pkg::DCOL_W-1:0]   blk_col_ext;

   assign req_pix = {req_red_in, req_green_in, req_blue_in};

   // ------------------------------------------------------------------
   // Handshake and flow control
   // ------------------------------------------------------------------
   assign out_load  = !rsp_valid_ff || !rsp_stall;
   assign emit      = job_valid_ff && out_load;
   assign job_done  = emit && (quad_ff == QUAD_LAST) && (mask_rest == 4'd0);
   assign job_free  = !job_valid_ff || job_done;
   // An item that releases nothing retires from stage one without the emitter.
   assign s1_leave  = s1_valid_ff && ((s1_mask_ff == 4'd0) || job_free);
   assign s1_to_job = s1_valid_ff && (s1_mask_ff != 4'd0) && job_free;
   assign req_stall = s1_valid_ff && !s1_leave;
   assign accept    = req_valid && !req_stall;

   // Position flags of the incoming item.
   assign last_col = (CNT_W'(col_ff) + CNT_W'(1)) == CNT_W'(width_ff);
   assign last_row = (CNT_W'(row_ff) + CNT_W'(1)) == CNT_W'(height_ff);

   // Blocks this item completes.
   assign new_mask[BLK_UP_LEFT] = (row_ff != '0) && (col_ff != '0);
   assign new_mask[BLK_UP]      = (row_ff != '0) && last_col;
   assign new_mask[BLK_LEFT]    = last_row && (col_ff != '0);
   assign new_mask[BLK_SELF]    = last_row && last_col;

   // ------------------------------------------------------------------
   // Line store: read the row above and write this pixel in the same cycle.
   // ------------------------------------------------------------------
   cbu_ram #(
      .WIDTH (cbu_pkg::PIX_W),
      .DEPTH (MAX_WIDTH)
   ) u_line (
      .clock (clock),
      .we    (accept),
      .waddr (col_ff),
      .wdata (req_pix),
      .re    (accept),
      .raddr (col_ff),
      .rdata (ram_rdata)
   );

   // ------------------------------------------------------------------
   // Frame position, registers and left-neighbor state
   // ------------------------------------------------------------------
   always_comb begin
      width_in      = width_ff;
      height_in     = height_ff;
      col_in        = col_ff;
      row_in        = row_ff;
      left_cur_in   = left_cur_ff;
      left_above_in = left_above_ff;

      if (accept) begin
         left_cur_in = req_pix;
         if (last_col) begin
            col_in = '0;
            row_in = last_row ? '0 : row_ff + ROW_ONE;
         end else begin
            col_in = col_ff + COL_ONE;
         end
      end
      if (s1_leave) begin
         left_above_in = ram_rdata;
      end

      // A register write restarts the frame.
      if (csr_we) begin
         case (csr_addr)
            cbu_pkg::REG_SRC_WIDTH: begin
               if (csr_wdata[cbu_pkg::WIDTH_W-1:0] == '0) begin
                  width_in = cbu_pkg::WIDTH_W'(1);
               end else if (32'(csr_wdata[cbu_pkg::WIDTH_W-1:0]) > MAX_WIDTH) begin
                  width_in = WIDTH_CLAMP;
               end else begin
                  width_in = csr_wdata[cbu_pkg::WIDTH_W-1:0];
               end
               col_in        = '0;
               row_in        = '0;
               left_cur_in   = '0;
               left_above_in = '0;
            end
            cbu_pkg::REG_SRC_HEIGHT: begin
               if (csr_wdata == '0) begin
                  height_in = cbu_pkg::HEIGHT_W'(1);
               end else if (csr_wdata > cbu_pkg::MAX_HEIGHT) begin
                  height_in = cbu_pkg::MAX_HEIGHT;
               end else begin
                  height_in = csr_wdata;
               end
               col_in        = '0;
               row_in        = '0;
               left_cur_in   = '0;
               left_above_in = '0;
            end
            default: begin
               width_in = width_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff      <= WIDTH_RESET;
         height_ff     <= cbu_pkg::HEIGHT_W'(1);
         col_ff        <= '0;
         row_ff        <= '0;
         left_cur_ff   <= '0;
         left_above_ff <= '0;
      end else begin
         width_ff      <= width_in;
         height_ff     <= height_in;
         col_ff        <= col_in;
         row_ff        <= row_in;
         left_cur_ff   <= left_cur_in;
         left_above_ff <= left_above_in;
      end
   end

   // ------------------------------------------------------------------
   // Stage one: item waits here while the line store is read.
   // ------------------------------------------------------------------
   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (accept) begin
         s1_valid_in = 1'b1;
      end else if (s1_leave) begin
         s1_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_cur_ff  <= req_pix;
         s1_lc_ff   <= left_cur_ff;
         s1_col_ff  <= col_ff;
         s1_row_ff  <= row_ff;
         s1_mask_ff <= new_mask;
      end
   end

   // ------------------------------------------------------------------
   // Emitter: walks the pending blocks, one destination pixel a cycle while not stalled.
   // ------------------------------------------------------------------
   always_comb begin
      if (job_mask_ff[BLK_UP_LEFT]) begin
         blk = BLK_UP_LEFT;
      end else if (job_mask_ff[BLK_UP]) begin
         blk = BLK_UP;
      end else if (job_mask_ff[BLK_LEFT]) begin
         blk = BLK_LEFT;
      end else begin
         blk = BLK_SELF;
      end
   end

   assign mask_rest = job_mask_ff & ~(4'd1 << blk);

   // Every output is the mean of four picks; a pair repeated gives a two-pixel mean.
   always_comb begin
      op_a = job_cur_ff;
      op_b = job_cur_ff;
      op_c = job_cur_ff;
      op_d = job_cur_ff;
      case ({blk, quad_ff})
         {BLK_UP_LEFT, 2'd0}: begin
            op_a = job_la_ff; op_b = job_la_ff; op_c = job_la_ff; op_d = job_la_ff;
         end
         {BLK_UP_LEFT, 2'd1}: begin
            op_a = job_la_ff; op_b = job_above_ff; op_c = job_la_ff; op_d = job_above_ff;
         end
         {BLK_UP_LEFT, 2'd2}: begin
            op_a = job_la_ff; op_b = job_lc_ff; op_c = job_la_ff; op_d = job_lc_ff;
         end
         {BLK_UP_LEFT, 2'd3}: begin
            op_a = job_la_ff; op_b = job_above_ff; op_c = job_lc_ff; op_d = job_cur_ff;
         end
         {BLK_UP, 2'd0}, {BLK_UP, 2'd1}: begin
            op_a = job_above_ff; op_b = job_above_ff;
            op_c = job_above_ff; op_d = job_above_ff;
         end
         {BLK_UP, 2'd2}, {BLK_UP, 2'd3}: begin
            op_a = job_above_ff; op_b = job_cur_ff; op_c = job_above_ff; op_d = job_cur_ff;
         end
         {BLK_LEFT, 2'd0}, {BLK_LEFT, 2'd2}: begin
            op_a = job_lc_ff; op_b = job_lc_ff; op_c = job_lc_ff; op_d = job_lc_ff;
         end
         {BLK_LEFT, 2'd1}, {BLK_LEFT, 2'd3}: begin
            op_a = job_lc_ff; op_b = job_cur_ff; op_c = job_lc_ff; op_d = job_cur_ff;
         end
         default: begin
            op_a = job_cur_ff;
         end
      endcase
   end

   assign emit_pix = avg4(op_a, op_b, op_c, op_d);

   // Source position of the current block.
   assign blk_col = (blk == BLK_UP_LEFT || blk == BLK_LEFT) ? job_col_ff - COL_ONE
                                                            : job_col_ff;
   assign blk_row = (blk == BLK_UP_LEFT || blk == BLK_UP) ? job_row_ff - ROW_ONE
                                                          : job_row_ff;
   assign blk_col_ext = cbu_pkg::DCOL_W'(blk_col);

   always_comb begin
      job_valid_in = job_valid_ff;
      job_mask_in  = job_mask_ff;
      quad_in      = quad_ff;
      if (emit) begin
         quad_in = quad_ff + 2'd1;
         if (quad_ff == QUAD_LAST) begin
            job_mask_in = mask_rest;
         end
         if (job_done) begin
            job_valid_in = 1'b0;
         end
      end
      if (s1_to_job) begin
         job_valid_in = 1'b1;
         job_mask_in  = s1_mask_ff;
         quad_in      = 2'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         job_valid_ff <= 1'b0;
         job_mask_ff  <= '0;
         quad_ff      <= '0;
      end else begin
         job_valid_ff <= job_valid_in;
         job_mask_ff  <= job_mask_in;
         quad_ff      <= quad_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_to_job) begin
         job_la_ff    <= left_above_ff;
         job_above_ff <= ram_rdata;
         job_lc_ff    <= s1_lc_ff;
         job_cur_ff   <= s1_cur_ff;
         job_col_ff   <= s1_col_ff;
         job_row_ff   <= s1_row_ff;
      end
   end

   // ------------------------------------------------------------------
   // Output register
   // ------------------------------------------------------------------
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         rsp_pix_ff  <= emit_pix;
         rsp_col_ff  <= {blk_col_ext[cbu_pkg::DCOL_W-2:0], quad_ff[0]};
         rsp_row_ff  <= {blk_row, quad_ff[1]};
         rsp_last_ff <= (quad_ff == QUAD_LAST) && (mask_rest == 4'd0);
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_red_out   = rsp_pix_ff[2*cbu_pkg::CHAN_W +: cbu_pkg::CHAN_W];
   assign rsp_green_out = rsp_pix_ff[cbu_pkg::CHAN_W +: cbu_pkg::CHAN_W];
   assign rsp_blue_out  = rsp_pix_ff[0 +: cbu_pkg::CHAN_W];
   assign rsp_dest_col  = rsp_col_ff;
   assign rsp_dest_row  = rsp_row_ff;
   assign rsp_run_last  = rsp_last_ff;

endmodule

### src/cbu_checker.sv
// Port-level checks on the result channel of the 2x bilinear upscaler.
// Depends on cbu_pkg; bound to the top level at the end of this file.
module cbu_checker (
   input logic                         clock,
   input logic                         reset,
   input logic                         rsp_valid,
   input logic                         rsp_stall,
   input logic [cbu_pkg::CHAN_W-1:0]   rsp_red_out,
   input logic [cbu_pkg::CHAN_W-1:0]   rsp_green_out,
   input logic [cbu_pkg::CHAN_W-1:0]   rsp_blue_out,
   input logic [cbu_pkg::DCOL_W-1:0]   rsp_dest_col,
   input logic [cbu_pkg::DROW_W-1:0]   rsp_dest_row,
   input logic                         rsp_run_last
);

   // A stalled item keeps its valid and its payload.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_red_out)
         && $stable(rsp_green_out) && $stable(rsp_blue_out)
         && $stable(rsp_dest_col) && $stable(rsp_dest_row) && $stable(rsp_run_last))
      else $error("result item changed while stalled");

   // Reset empties the output register.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

   // Every run of results ends on the bottom-right pixel of a block.
   a_last_corner: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_run_last |-> rsp_dest_col[0] && rsp_dest_row[0])
      else $error("last result of an item is not a bottom-right pixel");

   // A top-left pixel is always followed in the same block by more output.
   a_first_not_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_dest_col[0] && !rsp_dest_row[0] |-> !rsp_run_last)
      else $error("top-left pixel marked as last of its item");

endmodule

bind color_bilinear_upscale_2x cbu_checker u_cbu_checker (
   .clock         (clock),
   .reset         (reset),
   .rsp_valid     (rsp_valid),
   .rsp_stall     (rsp_stall),
   .rsp_red_out   (rsp_red_out),
   .rsp_green_out (rsp_green_out),
   .rsp_blue_out  (rsp_blue_out),
   .rsp_dest_col  (rsp_dest_col),
   .rsp_dest_row  (rsp_dest_row),
   .rsp_run_last  (rsp_run_last)
);

### tb/sv/tb_color_bilinear_upscale_2x.sv
// Self-checking testbench for color_bilinear_upscale_2x, the 2x bilinear RGB upscaler.
// Streams source pixels and register writes, predicts every destination pixel and checks
// the output stream item by item; depends on cbu_pkg and the top level only.
`timescale 1ns / 1ps

module tb_color_bilinear_upscale_2x;

   localparam int MAX_COLS      = 2048;
   localparam int CYCLE_LIMIT   = 1_500_000;
   localparam int DRAIN_LIMIT   = 5000;
   localparam int SETTLE_CYCLES = 20;
   localparam int RANDOM_ITEMS  = 180;
   localparam int MAX_REPORTS   = 30;
   localparam int HOLD_CYCLES   = 400;

   // One destination pixel as the output port presents it.
   typedef struct packed {
      logic [cbu_pkg::CHAN_W-1:0] red;
      logic [cbu_pkg::CHAN_W-1:0] green;
      logic [cbu_pkg::CHAN_W-1:0] blue;
      logic [cbu_pkg::DCOL_W-1:0] col;
      logic [cbu_pkg::DROW_W-1:0] row;
      logic                       last;
   } dest_pixel_type;

   typedef enum logic {STEP_PIXEL, STEP_WRITE} step_kind_type;

   // One row of the directed sequence. A typed row carries its own expectation:
   // either nothing, or one block whose right half is right_px and left half left_px.
   typedef struct packed {
      step_kind_type                  kind;
      logic [cbu_pkg::CSR_ADDR_W-1:0] addr;
      logic [cbu_pkg::CSR_DATA_W-1:0] data;
      cbu_pkg::pixel_type             px;
      logic                           typed;
      logic                           has_block;
      cbu_pkg::pixel_type             left_px;
      cbu_pkg::pixel_type             right_px;
      logic [10:0]                    src_col;
      logic [11:0]                    src_row;
   } step_row_type;

   logic                           clock;
   logic                           reset         = 1'b1;
   logic                           req_valid     = 1'b0;
   logic                           req_stall;
   logic [cbu_pkg::CHAN_W-1:0]     req_red_in    = '0;
   logic [cbu_pkg::CHAN_W-1:0]     req_green_in  = '0;
   logic [cbu_pkg::CHAN_W-1:0]     req_blue_in   = '0;
   logic                           rsp_valid;
   logic                           rsp_stall     = 1'b0;
   logic [cbu_pkg::CHAN_W-1:0]     rsp_red_out;
   logic [cbu_pkg::CHAN_W-1:0]     rsp_green_out;
   logic [cbu_pkg::CHAN_W-1:0]     rsp_blue_out;
   logic [cbu_pkg::DCOL_W-1:0]     rsp_dest_col;
   logic [cbu_pkg::DROW_W-1:0]     rsp_dest_row;
   logic                           rsp_run_last;
   logic                           csr_we        = 1'b0;
   logic [cbu_pkg::CSR_ADDR_W-1:0] csr_addr      = '0;
   logic [cbu_pkg::CSR_DATA_W-1:0] csr_wdata     = '0;

   // Predicted upscaler state and the destination pixels still owed by the block.
   cbu_pkg::pixel_type           line_store [0:MAX_COLS-1];
   cbu_pkg::pixel_type           left_cur;
   cbu_pkg::pixel_type           left_above;
   int                           col_pos;
   int                           row_pos;
   logic [cbu_pkg::WIDTH_W-1:0]  cfg_width;
   logic [cbu_pkg::HEIGHT_W-1:0] cfg_height;
   dest_pixel_type               pending_dest[$];

   bit  no_gaps        = 1'b0;
   bit  hold_armed     = 1'b0;
   int  sent_pixels    = 0;
   int  checked_pixels = 0;
   int  reg_writes     = 0;
   int  mismatch_count = 0;
   int  cycle_count    = 0;

   color_bilinear_upscale_2x u_top (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_red_in    (req_red_in),
      .req_green_in  (req_green_in),
      .req_blue_in   (req_blue_in),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_red_out   (rsp_red_out),
      .rsp_green_out (rsp_green_out),
      .rsp_blue_out  (rsp_blue_out),
      .rsp_dest_col  (rsp_dest_col),
      .rsp_dest_row  (rsp_dest_row),
      .rsp_run_last  (rsp_run_last),
      .csr_we        (csr_we),
      .csr_addr      (csr_addr),
      .csr_wdata     (csr_wdata)
   );

   // Clock and a single reset pulse at the start.
   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin
      repeat (7) @(negedge clock);
      reset <= 1'b0;
   end

   // Run limit in case the block hangs.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Timed out after %0d cycles with %0d pixels outstanding.",
                  cycle_count, pending_dest.size());
         $display("[color_bilinear_upscale_2x] ERROR");
         $finish;
      end
   end

   // Failure report, capped so that a broken block does not flood the log.
   task automatic flag(input string msg);
      mismatch_count++;
      if (mismatch_count <= MAX_REPORTS) $display("%s", msg);
      if (mismatch_count == MAX_REPORTS) $display("Further failures are counted only.");
   endtask

   // Per-channel truncating means of two and of four pixels.
   function automatic cbu_pkg::pixel_type mean2(input cbu_pkg::pixel_type a,
                                                input cbu_pkg::pixel_type b);
      cbu_pkg::pixel_type m;
      logic [8:0]         s;
      int                 k;
      for (k = 0; k < 3; k++) begin
         s = 9'(a[k*8 +: 8]) + 9'(b[k*8 +: 8]);
         m[k*8 +: 8] = s[8:1];
      end
      return m;
   endfunction

   function automatic cbu_pkg::pixel_type mean4(input cbu_pkg::pixel_type a,
                                                input cbu_pkg::pixel_type b,
                                                input cbu_pkg::pixel_type c,
                                                input cbu_pkg::pixel_type d);
      cbu_pkg::pixel_type m;
      logic [9:0]         s;
      int                 k;
      for (k = 0; k < 3; k++) begin
         s = 10'(a[k*8 +: 8]) + 10'(b[k*8 +: 8]) + 10'(c[k*8 +: 8]) + 10'(d[k*8 +: 8]);
         m[k*8 +: 8] = s[9:2];
      end
      return m;
   endfunction

   // Sizes in use: zero reads as one, oversize values saturate.
   function automatic int clamped_width();
      if (cfg_width < 1) return 1;
      if (cfg_width > MAX_COLS) return MAX_COLS;
      return int'(cfg_width);
   endfunction

   function automatic int clamped_height();
      if (cfg_height < 1) return 1;
      if (cfg_height > cbu_pkg::MAX_HEIGHT) return int'(cbu_pkg::MAX_HEIGHT);
      return int'(cfg_height);
   endfunction

   // Queue the 2x2 block of source pixel (sc, sr) in top-left, top-right,
   // bottom-left, bottom-right order.
   function automatic void push_block(input cbu_pkg::pixel_type p1,
                                      input cbu_pkg::pixel_type p2,
                                      input cbu_pkg::pixel_type p3,
                                      input cbu_pkg::pixel_type p4,
                                      input int sc, input int sr);
      cbu_pkg::pixel_type quad [0:3];
      dest_pixel_type     d;
      int                 k;
      quad[0] = p1;
      quad[1] = p2;
      quad[2] = p3;
      quad[3] = p4;
      for (k = 0; k < 4; k++) begin
         d.red   = quad[k][23:16];
         d.green = quad[k][15:8];
         d.blue  = quad[k][7:0];
         d.col   = cbu_pkg::DCOL_W'(2 * sc + (k % 2));
         d.row   = cbu_pkg::DROW_W'(2 * sr + (k / 2));
         d.last  = 1'b0;
         pending_dest.push_back(d);
      end
   endfunction

   // The last pixel queued for one source item carries run_last.
   function automatic void mark_last(input int n0);
      dest_pixel_type tail;
      if (pending_dest.size() > n0) begin
         tail = pending_dest.pop_back();
         tail.last = 1'b1;
         pending_dest.push_back(tail);
      end
   endfunction

   // Advance the predicted upscaler by one source pixel and queue what it releases.
   function automatic void upscale_pixel(input cbu_pkg::pixel_type cur);
      int                 w, h, c, r, n0;
      cbu_pkg::pixel_type above, lc, la, v;
      w = clamped_width();
      h = clamped_height();
      if (col_pos >= w) col_pos = 0;
      if (row_pos >= h) row_pos = 0;
      c = col_pos;
      r = row_pos;
      above = line_store[c];
      lc = left_cur;
      la = left_above;
      n0 = pending_dest.size();

      // Blocks of the row above, now that their lower neighbors are here.
      if (r >= 1) begin
         if (c >= 1)
            push_block(la, mean2(la, above), mean2(la, lc), mean4(la, above, lc, cur),
                       c - 1, r - 1);
         if (c == w - 1) begin
            v = mean2(above, cur);
            push_block(above, above, v, v, c, r - 1);
         end
      end
      // In the last row the bottom half of each block repeats the top half.
      if (r == h - 1) begin
         if (c >= 1) begin
            v = mean2(lc, cur);
            push_block(lc, v, lc, v, c - 1, r);
         end
         if (c == w - 1) push_block(cur, cur, cur, cur, c, r);
      end
      mark_last(n0);

      line_store[c] = cur;
      left_above = above;
      left_cur = cur;
      if (c + 1 >= w) begin
         col_pos = 0;
         row_pos = (r + 1 >= h) ? 0 : r + 1;
      end else begin
         col_pos = c + 1;
      end
   endfunction

   function automatic logic [cbu_pkg::CHAN_W-1:0] random_chan();
      case ($urandom_range(0, 7))
         0: return 8'h00;
         1: return 8'hff;
         default: return cbu_pkg::CHAN_W'($urandom_range(0, 255));
      endcase
   endfunction

   function automatic cbu_pkg::pixel_type random_pixel();
      return {random_chan(), random_chan(), random_chan()};
   endfunction

   // Builders for the directed sequence.
   function automatic step_row_type plain_pixel(input cbu_pkg::pixel_type px);
      step_row_type s;
      s = '0;
      s.kind = STEP_PIXEL;
      s.px = px;
      return s;
   endfunction

   function automatic step_row_type typed_pixel(input cbu_pkg::pixel_type px,
                                                input bit has_block,
                                                input cbu_pkg::pixel_type left_px,
                                                input cbu_pkg::pixel_type right_px,
                                                input int sc, input int sr);
      step_row_type s;
      s = plain_pixel(px);
      s.typed = 1'b1;
      s.has_block = has_block;
      s.left_px = left_px;
      s.right_px = right_px;
      s.src_col = 11'(sc);
      s.src_row = 12'(sr);
      return s;
   endfunction

   function automatic step_row_type reg_step(input logic [cbu_pkg::CSR_ADDR_W-1:0] idx,
                                             input int val);
      step_row_type s;
      s = '0;
      s.kind = STEP_WRITE;
      s.addr = idx;
      s.data = cbu_pkg::CSR_DATA_W'(val);
      return s;
   endfunction

   // Offer one source pixel after a random gap and return once it is taken.
   task automatic send_pixel(input cbu_pkg::pixel_type px);
      int gap;
      gap = no_gaps ? 0 : $urandom_range(0, 4);
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_red_in <= px[23:16];
      req_green_in <= px[15:8];
      req_blue_in <= px[7:0];
      do @(posedge clock); while (req_stall);
      sent_pixels++;
   endtask

   // Stop offering, wait for every owed pixel, then let the pipeline settle
   // since the last items may have released nothing.
   task automatic drain_results();
      int waited;
      waited = 0;
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_dest.size() != 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      if (pending_dest.size() != 0) begin
         flag($sformatf("%0t: %0d destination pixels never arrived", $time,
                        pending_dest.size()));
         pending_dest.delete();
      end
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // Register write while idle; any write restarts the frame.
   task automatic write_reg(input logic [cbu_pkg::CSR_ADDR_W-1:0] idx, input int val);
      logic [cbu_pkg::CSR_DATA_W-1:0] data;
      data = cbu_pkg::CSR_DATA_W'(val);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_addr <= idx;
      csr_wdata <= data;
      @(negedge clock);
      csr_we <= 1'b0;
      case (idx)
         cbu_pkg::REG_SRC_WIDTH:  cfg_width = data[cbu_pkg::WIDTH_W-1:0];
         cbu_pkg::REG_SRC_HEIGHT: cfg_height = data[cbu_pkg::HEIGHT_W-1:0];
         default: ;
      endcase
      col_pos = 0;
      row_pos = 0;
      left_cur = '0;
      left_above = '0;
      reg_writes++;
   endtask

   task automatic stream_pixels(input int n);
      cbu_pkg::pixel_type px;
      no_gaps = ($urandom_range(0, 3) == 0);
      repeat (n) begin
         px = random_pixel();
         send_pixel(px);
         upscale_pixel(px);
      end
   endtask

   // Stimulus: directed sequence, random frames, then the largest sizes.
   initial begin : stimulus
      step_row_type directed_steps[$];
      step_row_type s;
      int           n0, w, h, n, frame, random_sent;
      bit           set_w, set_h;

      // Reset values: one row of maximum width.
      directed_steps.push_back(typed_pixel(24'h000000, 1'b0, '0, '0, 0, 0));
      directed_steps.push_back(typed_pixel(24'hffffff, 1'b1, 24'h000000, 24'h7f7f7f, 0, 0));
      directed_steps.push_back(typed_pixel(24'hff00ff, 1'b1, 24'hffffff, 24'hff7fff, 1, 0));
      // Single-pixel frames: each item wraps the frame and copies itself four times.
      directed_steps.push_back(reg_step(cbu_pkg::REG_SRC_WIDTH, 1));
      directed_steps.push_back(typed_pixel(24'h8001fe, 1'b1, 24'h8001fe, 24'h8001fe, 0, 0));
      directed_steps.push_back(typed_pixel(24'hffffff, 1'b1, 24'hffffff, 24'hffffff, 0, 0));
      // Zero width behaves as one.
      directed_steps.push_back(reg_step(cbu_pkg::REG_SRC_WIDTH, 0));
      directed_steps.push_back(typed_pixel(24'h123456, 1'b1, 24'h123456, 24'h123456, 0, 0));
      // Zero height behaves as one; the right column copies its left half.
      directed_steps.push_back(reg_step(cbu_pkg::REG_SRC_WIDTH, 3));
      directed_steps.push_back(reg_step(cbu_pkg::REG_SRC_HEIGHT, 0));
      directed_steps.push_back(typed_pixel(24'hffffff, 1'b0, '0, '0, 0, 0));
      directed_steps.push_back(typed_pixel(24'hffffff, 1'b1, 24'hffffff, 24'hffffff, 0, 0));
      directed_steps.push_back(plain_pixel(24'h010101));
      // A 2x2 frame: the last pixel releases all four blocks.
      directed_steps.push_back(reg_step(cbu_pkg::REG_SRC_WIDTH, 2));
      directed_steps.push_back(reg_step(cbu_pkg::REG_SRC_HEIGHT, 2));
      directed_steps.push_back(typed_pixel(24'hff0000, 1'b0, '0, '0, 0, 0));
      directed_steps.push_back(typed_pixel(24'h00ff00, 1'b0, '0, '0, 0, 0));
      directed_steps.push_back(typed_pixel(24'h0000ff, 1'b0, '0, '0, 0, 0));
      directed_steps.push_back(plain_pixel(24'hffffff));
      // A 3x3 frame with odd sums to exercise truncation.
      directed_steps.push_back(reg_step(cbu_pkg::REG_SRC_WIDTH, 3));
      directed_steps.push_back(reg_step(cbu_pkg::REG_SRC_HEIGHT, 3));
      directed_steps.push_back(plain_pixel(24'h010203));
      directed_steps.push_back(plain_pixel(24'hfefdfc));
      directed_steps.push_back(plain_pixel(24'h00ff01));
      directed_steps.push_back(plain_pixel(24'h7f8081));
      directed_steps.push_back(plain_pixel(24'hff00ff));
      directed_steps.push_back(plain_pixel(24'h030201));
      directed_steps.push_back(plain_pixel(24'h80807f));
      directed_steps.push_back(plain_pixel(24'h00ffff));
      directed_steps.push_back(plain_pixel(24'hfe01fe));

      cfg_width = 12'd2048;
      cfg_height = 13'd1;
      col_pos = 0;
      row_pos = 0;
      left_cur = '0;
      left_above = '0;
      while (reset) @(negedge clock);

      // A typed row replaces the predicted pixels with the ones written above.
      foreach (directed_steps[i]) begin
         s = directed_steps[i];
         if (s.kind == STEP_WRITE) begin
            drain_results();
            write_reg(s.addr, int'(s.data));
         end else begin
            send_pixel(s.px);
            n0 = pending_dest.size();
            upscale_pixel(s.px);
            if (s.typed) begin
               while (pending_dest.size() > n0) void'(pending_dest.pop_back());
               if (s.has_block)
                  push_block(s.left_px, s.right_px, s.left_px, s.right_px,
                             s.src_col, s.src_row);
               mark_last(n0);
            end
         end
      end

      // Random small frames, mostly whole frames with a partial tail.
      random_sent = 0;
      while (random_sent < RANDOM_ITEMS) begin
         case ($urandom_range(0, 9))
            0: w = 0;
            1: w = 16;
            default: w = $urandom_range(1, 8);
         endcase
         case ($urandom_range(0, 9))
            0: h = 0;
            1: h = 7;
            default: h = $urandom_range(1, 5);
         endcase
         case ($urandom_range(0, 3))
            0: begin set_w = 1'b1; set_h = 1'b0; end
            1: begin set_w = 1'b0; set_h = 1'b1; end
            default: begin set_w = 1'b1; set_h = 1'b1; end
         endcase
         drain_results();
         if (set_w) write_reg(cbu_pkg::REG_SRC_WIDTH, w);
         if (set_h) write_reg(cbu_pkg::REG_SRC_HEIGHT, h);
         frame = clamped_width() * clamped_height();
         n = $urandom_range(1, 2) * frame + $urandom_range(0, clamped_width());
         if (n > 60) n = $urandom_range(20, 60);
         stream_pixels(n);
         random_sent += n;
      end

      // Largest sizes: the first row at full width, a tall narrow strip, a row
      // under a clamped width while the output is held off, and a column under
      // a clamped height.
      drain_results();
      write_reg(cbu_pkg::REG_SRC_WIDTH, 2048);
      write_reg(cbu_pkg::REG_SRC_HEIGHT, 2);
      stream_pixels(30);
      drain_results();
      write_reg(cbu_pkg::REG_SRC_WIDTH, 2);
      write_reg(cbu_pkg::REG_SRC_HEIGHT, 4096);
      stream_pixels(40);
      drain_results();
      write_reg(cbu_pkg::REG_SRC_WIDTH, 4095);
      write_reg(cbu_pkg::REG_SRC_HEIGHT, 1);
      hold_armed = 1'b1;
      stream_pixels(40);
      drain_results();
      write_reg(cbu_pkg::REG_SRC_WIDTH, 1);
      write_reg(cbu_pkg::REG_SRC_HEIGHT, 8191);
      stream_pixels(40);
      drain_results();

      $display("Sent %0d source pixels under %0d register writes; checked %0d output pixels.",
               sent_pixels, reg_writes, checked_pixels);
      $display("Frames ranged from one pixel to clamped width and height, with one long"
               , " output hold.");
      if (mismatch_count == 0) begin
         $display("[color_bilinear_upscale_2x] OK");
      end else begin
         $display("%0d failures.", mismatch_count);
         $display("[color_bilinear_upscale_2x] ERROR");
      end
      $finish;
   end

   // Output side: random stall before each item, one long hold-off once, and a
   // field-by-field comparison against the oldest owed pixel.
   initial begin : result_checker
      int             hold;
      bit             held_off;
      dest_pixel_type got, want;
      held_off = 1'b0;
      while (reset) @(negedge clock);
      forever begin
         hold = no_gaps ? 0 : $urandom_range(0, 4);
         if (!held_off && hold_armed) begin
            hold = HOLD_CYCLES;
            held_off = 1'b1;
         end
         @(negedge clock);
         if (hold > 0) begin
            rsp_stall <= 1'b1;
            repeat (hold) @(negedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!rsp_valid);
         got = {rsp_red_out, rsp_green_out, rsp_blue_out, rsp_dest_col, rsp_dest_row,
                rsp_run_last};
         checked_pixels++;
         if (pending_dest.size() == 0) begin
            flag($sformatf("%0t: unexpected pixel rgb %02h%02h%02h col %0d row %0d last %0b",
                           $time, got.red, got.green, got.blue, got.col, got.row,
                           got.last));
         end else begin
            want = pending_dest.pop_front();
            if (got.red !== want.red || got.green !== want.green || got.blue !== want.blue ||
                got.col !== want.col || got.row !== want.row || got.last !== want.last)
               flag($sformatf({"%0t: expected rgb %02h%02h%02h col %0d row %0d last %0b,",
                               " got rgb %02h%02h%02h col %0d row %0d last %0b"},
                              $time, want.red, want.green, want.blue, want.col, want.row,
                              want.last, got.red, got.green, got.blue, got.col, got.row,
                              got.last));
         end
      end
   end

endmodule

### color_bilinear_upscale_2x.f
src/cbu_pkg.sv
src/cbu_ram.sv
src/color_bilinear_upscale_2x.sv
src/cbu_checker.sv
tb/sv/tb_color_bilinear_upscale_2x.sv
